// ===== rtl/clw_pkg.sv =====
// Shared types, constants and helpers for the character LCD text writer.
// No dependencies; imported by clw_addr_unit and char_lcd_text_writer.
package clw_pkg;

  // Wide enough for a padded position up to twice the widest line (80).
  localparam int unsigned PosW      = 7;
  localparam int unsigned CursorW   = 6;
  localparam int unsigned PadCntW   = 5;
  localparam int unsigned MaxPadCells = 16;

  localparam logic [7:0] CmdAddrRow0  = 8'h80;
  localparam logic [7:0] CmdAddrRow1  = 8'hC0;
  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CharSpace    = 8'h20;
  localparam logic [7:0] CharNewline  = 8'h0A;
  localparam logic [7:0] CharBackspace = 8'h08;

  typedef enum logic [1:0] {
    REQ_WRITE      = 2'd0,
    REQ_SET_CURSOR = 2'd1,
    REQ_CLEAR      = 2'd2
  } req_e;

  typedef struct packed {
    logic       done;
    logic [7:0] addr;
  } addr_sts_t;

  // The four data pins are wired in reverse order.
  function automatic logic [3:0] rev4(input logic [3:0] v);
    return {v[0], v[1], v[2], v[3]};
  endfunction

endpackage

// ===== rtl/clw_addr_unit.sv =====
// Set-address command builder: splits a cursor position into row and column
// by repeated subtraction of the line length. Depends on clw_pkg.
module clw_addr_unit import clw_pkg::*; #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PosW-1:0] pos_i,
  output addr_sts_t       sts_o
);

  localparam logic [PosW-1:0] Cols = PosW'(COLUMNS);

  logic            busy_q;
  logic            row1_q;
  logic [PosW-1:0] rem_q;
  logic            ge;

  assign ge = (rem_q >= Cols);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row1_q <= 1'b0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      row1_q <= 1'b0;
      rem_q  <= pos_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_q  <= rem_q - Cols;
        row1_q <= 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  assign sts_o.done = busy_q && !ge;
  assign sts_o.addr = (row1_q ? CmdAddrRow1 : CmdAddrRow0) + {1'b0, rem_q};

endmodule

// ===== rtl/char_lcd_text_writer.sv =====
// Top level of the character LCD text writer: request sequencer, cursor and
// nibble output register. Depends on clw_pkg and clw_addr_unit.
//
// Takes one request at a time and turns it into 4-bit bus transactions for a
// two-line character LCD; each nibble is bit-reversed and carries register
// select, and last marks the final nibble of a request. Set cursor and the
// unused request code send nothing. Clear sends two nibbles. Every written
// cell (a character, a backspace blank, or each pad cell of a newline) first
// has its set-address command formed by repeated subtraction in the shared
// subtract unit, then sends four nibbles; a newline pads up to 16 cells. The
// output register lets the next request enter while the last nibble still
// waits; output stalls hold the sequencer in its emit state.
module char_lcd_text_writer import clw_pkg::*; #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] new_position_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       reg_select_o,
  output logic [3:0] pin_nibble_o,
  output logic       last_o
);

  localparam logic [PosW-1:0]    Cols   = PosW'(COLUMNS);
  localparam logic [PosW-1:0]    Cols2  = PosW'(2 * COLUMNS);
  localparam logic [CursorW-1:0] ColCur = CursorW'(COLUMNS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [CursorW-1:0]  cursor_q;
  logic [PosW-1:0]     pos_q;
  logic [PadCntW-1:0]  cells_q;
  logic [1:0]          nib_q;
  logic                single_q;
  logic [7:0]          cmd_q;
  logic [7:0]          data_q;
  logic                out_valid_q;
  logic                out_valid_d;
  logic                rs_q;
  logic [3:0]          pin_q;
  logic                last_q;

  logic                in_acc;
  logic                slot_free;
  logic [PosW-1:0]     cur_pos;
  logic [PosW-1:0]     nl_end;
  logic [PosW-1:0]     nl_diff;
  logic [PadCntW-1:0]  nl_cells;
  logic [PosW-1:0]     wr_pos;
  logic [PadCntW-1:0]  wr_cells;
  logic [7:0]          wr_data;
  logic [CursorW-1:0]  wr_cursor;
  logic                cell_end;
  logic                item_end;
  logic [7:0]          cur_byte;
  logic [3:0]          cur_half;
  logic                unit_start;
  logic [PosW-1:0]     unit_pos;
  addr_sts_t           unit_sts;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign cur_pos    = {1'b0, cursor_q};

  // Load a new nibble when emitting, hold a waiting one, drop an accepted one.
  assign out_valid_d = ((state_q == ST_EMIT) && slot_free) ||
                       (out_valid_q && !out_ready_i);

  // Decode a write request: position, cell count, data byte, next cursor.
  always_comb begin
    nl_end   = (cur_pos <= Cols) ? Cols : Cols2;
    nl_diff  = nl_end - cur_pos;
    nl_cells = '0;
    if (cur_pos < nl_end) begin
      nl_cells = (nl_diff >= PosW'(MaxPadCells)) ? PadCntW'(MaxPadCells)
                                                 : PadCntW'(nl_diff);
    end
    wr_pos    = cur_pos;
    wr_cells  = PadCntW'(1);
    wr_data   = CharSpace;
    wr_cursor = cursor_q + CursorW'(1);
    if (char_code_i == CharNewline) begin
      wr_cells  = nl_cells;
      wr_cursor = (cur_pos <= Cols) ? ColCur : '0;
    end else if (char_code_i == CharBackspace) begin
      wr_pos    = (cursor_q != '0) ? cur_pos - PosW'(1) : cur_pos;
      wr_cursor = wr_pos[CursorW-1:0];
    end else if (char_code_i >= CharSpace) begin
      wr_data = char_code_i;
    end
  end

  assign cell_end = single_q ? (nib_q == 2'd1) : (nib_q == 2'd3);
  assign item_end = cell_end && (single_q || cells_q == PadCntW'(1));
  assign cur_byte = nib_q[1] ? data_q : cmd_q;
  assign cur_half = nib_q[0] ? cur_byte[3:0] : cur_byte[7:4];

  always_comb begin
    unit_start = 1'b0;
    unit_pos   = pos_q + PosW'(1);
    if (in_acc && req_type_i == REQ_WRITE && wr_cells != '0) begin
      unit_start = 1'b1;
      unit_pos   = wr_pos;
    end else if (state_q == ST_EMIT && slot_free && cell_end && !item_end) begin
      unit_start = 1'b1;
    end
  end

  clw_addr_unit #(
    .COLUMNS(COLUMNS)
  ) u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(unit_start),
    .pos_i  (unit_pos),
    .sts_o  (unit_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      pos_q       <= '0;
      cells_q     <= '0;
      nib_q       <= '0;
      single_q    <= 1'b0;
      cmd_q       <= '0;
      data_q      <= '0;
      out_valid_q <= 1'b0;
      rs_q        <= 1'b0;
      pin_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (req_type_i)
              REQ_SET_CURSOR: cursor_q <= new_position_i;
              REQ_CLEAR: begin
                cursor_q <= '0;
                cmd_q    <= CmdClear;
                single_q <= 1'b1;
                nib_q    <= '0;
                state_q  <= ST_EMIT;
              end
              REQ_WRITE: begin
                cursor_q <= wr_cursor;
                pos_q    <= wr_pos;
                cells_q  <= wr_cells;
                data_q   <= wr_data;
                single_q <= 1'b0;
                if (wr_cells != '0) begin
                  state_q <= ST_ADDR;
                end
              end
              default: ;  // unused code: drop
            endcase
          end
        end
        ST_ADDR: begin
          if (unit_sts.done) begin
            cmd_q   <= unit_sts.addr;
            nib_q   <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            rs_q        <= nib_q[1];
            pin_q       <= rev4(cur_half);
            last_q      <= item_end;
            if (item_end) begin
              state_q <= ST_IDLE;
            end else if (cell_end) begin
              // advance to the next pad cell
              cells_q <= cells_q - PadCntW'(1);
              pos_q   <= pos_q + PosW'(1);
              state_q <= ST_ADDR;
            end else begin
              nib_q <= nib_q + 2'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reg_select_o = rs_q;
  assign pin_nibble_o = pin_q;
  assign last_o       = last_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for char_lcd_text_writer: scoreboard class, drivers and monitor.
// Depends on clw_pkg and the char_lcd_text_writer RTL; needs no files or arguments.
module tb_top;
  import clw_pkg::*;

  localparam int unsigned Columns   = 16;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned NumRandom = 256;
  localparam logic [1:0]  ReqUnused = 2'd3;

  typedef struct packed {
    logic       rs;
    logic [3:0] pins;
    logic       last;
  } nibble_t;

  class LcdNibbleBoard;
    logic [5:0] cursor = '0;
    nibble_t    pending[$];
    int         errors = 0;
    int         checked = 0;
    int         requests = 0;
    int         newlines = 0;
    int         backspaces = 0;
    int         clears = 0;

    function logic [3:0] flip(input logic [3:0] v);
      logic [3:0] r;
      for (int i = 0; i < 4; i++) r[3-i] = v[i];
      return r;
    endfunction

    function void push_byte(input logic rs, input logic [7:0] b);
      pending.push_back('{rs: rs, pins: flip(b[7:4]), last: 1'b0});
      pending.push_back('{rs: rs, pins: flip(b[3:0]), last: 1'b0});
    endfunction

    // Address command, then the character itself.
    function void push_cell(input int unsigned p, input logic [7:0] code);
      logic [7:0] addr;
      addr = ((p / Columns == 0) ? CmdAddrRow0 : CmdAddrRow1) + 8'(p % Columns);
      push_byte(1'b0, addr);
      push_byte(1'b1, code);
    endfunction

    function void note_request(input logic [1:0] req, input logic [7:0] ch,
                               input logic [5:0] npos);
      int unsigned p;
      int unsigned pad_end;
      int unsigned cells;
      int          first;
      logic [7:0]  code;
      first = pending.size();
      requests++;
      case (req)
        REQ_SET_CURSOR: cursor = npos;
        REQ_CLEAR: begin
          clears++;
          push_byte(1'b0, CmdClear);
          cursor = '0;
        end
        REQ_WRITE: begin
          p = int'(cursor);
          if (ch == CharNewline) begin
            newlines++;
            if (p <= Columns) begin
              pad_end = Columns;
              cursor = 6'(Columns);
            end else begin
              pad_end = 2 * Columns;
              cursor = '0;
            end
            cells = 0;
            while (p < pad_end && cells < MaxPadCells) begin
              push_cell(p, CharSpace);
              p++;
              cells++;
            end
          end else if (ch == CharBackspace) begin
            backspaces++;
            if (p > 0) p--;
            cursor = 6'(p);
            push_cell(p, CharSpace);
          end else begin
            code = (ch < CharSpace) ? CharSpace : ch;
            push_cell(p, code);
            cursor = cursor + 6'd1;
          end
        end
        default: ;  // unused request code: drop it
      endcase
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void report(input string msg);
      errors++;
      if (errors <= 10) $display("  error: %s", msg);
    endfunction

    function void check_nibble(input logic rs, input logic [3:0] pins, input logic lst);
      nibble_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected nibble rs=%0b pins=%h last=%0b", rs, pins, lst));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.rs !== rs || want.pins !== pins || want.last !== lst)
        report($sformatf({"nibble %0d: expected rs=%0b pins=%h last=%0b, ",
                          "got rs=%0b pins=%h last=%0b"},
                         checked, want.rs, want.pins, want.last, rs, pins, lst));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i = REQ_WRITE;
  logic [7:0] char_code_i = '0;
  logic [5:0] new_position_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       reg_select_o;
  logic [3:0] pin_nibble_o;
  logic       last_o;

  logic        gaps_on = 1'b1;
  int unsigned idle_cycles = 0;

  LcdNibbleBoard board = new();

  char_lcd_text_writer #(.COLUMNS(Columns)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .char_code_i,
    .new_position_i, .out_valid_o, .out_ready_i, .reg_select_o, .pin_nibble_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= !gaps_on || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_nibble(reg_select_o, pin_nibble_o, last_o);
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no transaction for %0d cycles", IdleLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                              input logic [5:0] npos);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 21) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    char_code_i    <= ch;
    new_position_i <= npos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(req, ch, npos);
  endtask

  task automatic send_random_request(output logic [1:0] req);
    int unsigned pick;
    int unsigned kind;
    logic [7:0]  ch;
    logic [5:0]  npos;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    npos = (kind < 50) ? 6'($urandom_range(0, 31)) : 6'($urandom_range(0, 63));
    if (pick < 62) begin
      req = REQ_WRITE;
      if (kind < 8)       ch = CharNewline;
      else if (kind < 16) ch = CharBackspace;
      else if (kind < 24) ch = 8'($urandom_range(0, 31));
      else if (kind < 60) ch = 8'($urandom_range(32, 126));
    end else if (pick < 88) begin
      req = REQ_SET_CURSOR;
    end else if (pick < 96) begin
      req = REQ_CLEAR;
    end else begin
      req = ReqUnused;
    end
    send_request(req, ch, npos);
  endtask

  initial begin
    int         sent;
    logic [1:0] req;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: character ranges, control codes, newline and backspace corners, wrap.
    send_request(REQ_WRITE, 8'h41, 6'd0);
    send_request(REQ_WRITE, 8'h00, 6'd0);
    send_request(REQ_WRITE, 8'h1F, 6'd0);
    send_request(REQ_WRITE, 8'hFF, 6'd0);
    send_request(REQ_WRITE, 8'h20, 6'd0);
    send_request(REQ_WRITE, CharNewline, 6'd0);
    send_request(REQ_WRITE, CharNewline, 6'd0);
    send_request(REQ_WRITE, 8'h7F, 6'd0);
    send_request(REQ_SET_CURSOR, 8'h00, 6'd20);
    send_request(REQ_WRITE, CharNewline, 6'd0);
    send_request(REQ_SET_CURSOR, 8'hFF, 6'd40);
    send_request(REQ_WRITE, 8'h5A, 6'd0);
    send_request(REQ_WRITE, CharNewline, 6'd0);
    send_request(REQ_WRITE, CharBackspace, 6'd0);
    send_request(REQ_SET_CURSOR, 8'h00, 6'd63);
    send_request(REQ_WRITE, 8'h80, 6'd0);
    send_request(REQ_SET_CURSOR, 8'h00, 6'd17);
    send_request(REQ_WRITE, CharBackspace, 6'd0);
    send_request(REQ_SET_CURSOR, 8'h00, 6'd17);
    send_request(REQ_WRITE, CharNewline, 6'd0);
    send_request(ReqUnused, 8'hFF, 6'd63);
    send_request(REQ_WRITE, CharNewline, 6'd0);
    send_request(REQ_CLEAR, 8'hFF, 6'd63);
    send_request(REQ_WRITE, 8'h30, 6'd0);

    // Random: hold off idling on both sides for a middle stretch.
    sent = 0;
    while (sent < NumRandom) begin
      gaps_on <= !(sent >= 120 && sent < 180);
      send_random_request(req);
      if (req != ReqUnused) sent++;
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d requests: %0d newlines, %0d backspaces, %0d clears",
             board.requests, board.newlines, board.backspaces, board.clears);
    $display("Compared %0d nibbles, %0d errors", board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== char_lcd_text_writer.f =====
rtl/clw_pkg.sv
rtl/clw_addr_unit.sv
rtl/char_lcd_text_writer.sv
tb/tb_top.sv
